### src/icfe_pkg.sv
// ----------------------------------------------------------------------------
// icfe_pkg
// Shared types and constants of the serial programming frame encoder.
// ----------------------------------------------------------------------------
package icfe_pkg;

    // Field widths of the request, the byte beat and the configuration port.
    localparam int ACTION_W    = 4;
    localparam int ADDR_W      = 17;
    localparam int BYTE_W      = 8;
    localparam int PAGE_W      = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int FRAME_LEN   = 4;
    localparam int FRAME_IDX_W = 2;
    localparam int QUEUE_DEPTH = 2;

    // Request codes.
    typedef enum logic [ACTION_W-1:0] {
        ACT_ENABLE    = 4'd0,
        ACT_SIG0      = 4'd1,
        ACT_EXT_ADDR  = 4'd2,
        ACT_RD_FLASH  = 4'd3,
        ACT_WR_FLASH  = 4'd4,
        ACT_WR_PAGE   = 4'd5,
        ACT_RD_EEPROM = 4'd6,
        ACT_WR_EEPROM = 4'd7,
        ACT_RESET     = 4'd8
    } action_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_EXT_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE = 2'd1;

    // Instruction bytes.
    localparam logic [BYTE_W-1:0] OP_PROG_EN1    = 8'hAC;
    localparam logic [BYTE_W-1:0] OP_PROG_EN2    = 8'h53;
    localparam logic [BYTE_W-1:0] OP_READ_SIG    = 8'h30;
    localparam logic [BYTE_W-1:0] OP_LOAD_EXT    = 8'h4D;
    localparam logic [BYTE_W-1:0] OP_READ_FLASH  = 8'h20;
    localparam logic [BYTE_W-1:0] OP_LOAD_PAGE   = 8'h40;
    localparam logic [BYTE_W-1:0] OP_WRITE_PAGE  = 8'h4C;
    localparam logic [BYTE_W-1:0] OP_READ_EEPROM = 8'hA0;
    localparam logic [BYTE_W-1:0] OP_WRITE_EEPROM = 8'hC0;
    localparam logic [BYTE_W-1:0] EXT_ADDR_RESET = 8'hFF;

    // One encoded frame: byte 0 goes out first.
    typedef struct packed {
        logic [FRAME_LEN-1:0][BYTE_W-1:0] bytes;
        logic                             cap_en;
        logic [FRAME_IDX_W-1:0]           cap_idx;
    } frame_t;

    // Frame queue status seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

### src/icfe_if.sv
// ----------------------------------------------------------------------------
// icfe interfaces
// Request, byte and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface icfe_req_if;
    logic                          valid;
    logic                          ready;
    logic [icfe_pkg::ACTION_W-1:0] action;
    logic [icfe_pkg::ADDR_W-1:0]   target_address;
    logic [icfe_pkg::BYTE_W-1:0]   write_data;
    logic [icfe_pkg::BYTE_W-1:0]   extended_address;

    modport source (output valid, action, target_address, write_data,
                    extended_address, input ready);
    modport sink   (input valid, action, target_address, write_data,
                    extended_address, output ready);
endinterface

interface icfe_byte_if;
    logic                        valid;
    logic                        ready;
    logic [icfe_pkg::BYTE_W-1:0] tx_byte;
    logic                        last_of_frame;
    logic                        capture_reply;

    modport source (output valid, tx_byte, last_of_frame, capture_reply, input ready);
    modport sink   (input valid, tx_byte, last_of_frame, capture_reply, output ready);
endinterface

interface icfe_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [icfe_pkg::CFG_IDX_W-1:0]  index;
    logic [icfe_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/icfe_front.sv
// ----------------------------------------------------------------------------
// icfe_front
// Accepts requests, holds the configuration and the extended address cache,
// and turns each request that needs one into a four-byte frame for the queue.
// ----------------------------------------------------------------------------
module icfe_front (
    input  logic                   clk,
    input  logic                   rst_n,
    icfe_req_if.sink               req,
    icfe_cfg_if.sink               cfg,
    input  icfe_pkg::queue_status_t q_status,
    output logic                   push,
    output icfe_pkg::frame_t       frame
);

    logic                          ext_mode_reg;
    logic [icfe_pkg::PAGE_W-1:0]   page_size_reg;
    logic [icfe_pkg::BYTE_W-1:0]   cache_reg;
    logic [icfe_pkg::BYTE_W-1:0]   cache_next;
    logic                          emit;
    logic                          accept;
    logic [icfe_pkg::BYTE_W-1:0]   sel_op;
    logic [15:0]                   page_mask;
    logic [15:0]                   page_lo;
    logic [icfe_pkg::ADDR_W-1:0]   page_addr;

    // Requests are taken whenever the queue has room; config is always taken.
    assign req.ready = !q_status.full;
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;
    assign push      = accept && emit;

    // Byte select bit of the flash opcodes.
    assign sel_op = {4'b0000, req.target_address[0], 3'b000};

    // Page boundary masking of the low 16 address bits.
    assign page_mask = ~({5'b00000, page_size_reg} - 16'd1);
    assign page_lo   = (page_size_reg != '0) ? (req.target_address[15:0] & page_mask)
                                             : req.target_address[15:0];
    assign page_addr = {req.target_address[16], page_lo};

    // Request decode and frame build.
    always_comb
    begin
        frame         = '0;
        emit          = 1'b0;
        cache_next    = cache_reg;
        case (icfe_pkg::action_t'(req.action))
            icfe_pkg::ACT_ENABLE:
            begin
                frame.bytes   = {8'h00, 8'h00, icfe_pkg::OP_PROG_EN2, icfe_pkg::OP_PROG_EN1};
                frame.cap_en  = 1'b1;
                frame.cap_idx = 2'd2;
                emit          = 1'b1;
                cache_next    = icfe_pkg::EXT_ADDR_RESET;
            end
            icfe_pkg::ACT_SIG0:
            begin
                frame.bytes   = {8'h00, 8'h00, 8'h00, icfe_pkg::OP_READ_SIG};
                frame.cap_en  = 1'b1;
                frame.cap_idx = 2'd3;
                emit          = 1'b1;
            end
            icfe_pkg::ACT_EXT_ADDR:
            begin
                frame.bytes = {8'h00, req.extended_address, 8'h00, icfe_pkg::OP_LOAD_EXT};
                if (ext_mode_reg && (req.extended_address != cache_reg))
                begin
                    emit       = 1'b1;
                    cache_next = req.extended_address;
                end
            end
            icfe_pkg::ACT_RD_FLASH:
            begin
                frame.bytes   = {8'h00, req.target_address[8:1], req.target_address[16:9],
                                 icfe_pkg::OP_READ_FLASH | sel_op};
                frame.cap_en  = 1'b1;
                frame.cap_idx = 2'd3;
                emit          = 1'b1;
            end
            icfe_pkg::ACT_WR_FLASH:
            begin
                frame.bytes = {req.write_data, req.target_address[8:1],
                               req.target_address[16:9], icfe_pkg::OP_LOAD_PAGE | sel_op};
                emit        = 1'b1;
            end
            icfe_pkg::ACT_WR_PAGE:
            begin
                frame.bytes = {8'h00, page_addr[8:1], page_addr[16:9],
                               icfe_pkg::OP_WRITE_PAGE};
                emit        = 1'b1;
            end
            icfe_pkg::ACT_RD_EEPROM:
            begin
                frame.bytes   = {8'h00, req.target_address[7:0], req.target_address[15:8],
                                 icfe_pkg::OP_READ_EEPROM};
                frame.cap_en  = 1'b1;
                frame.cap_idx = 2'd3;
                emit          = 1'b1;
            end
            icfe_pkg::ACT_WR_EEPROM:
            begin
                frame.bytes = {req.write_data, req.target_address[7:0],
                               req.target_address[15:8], icfe_pkg::OP_WRITE_EEPROM};
                emit        = 1'b1;
            end
            icfe_pkg::ACT_RESET:
            begin
                cache_next = icfe_pkg::EXT_ADDR_RESET;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Configuration registers and the extended address cache.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_mode_reg  <= 1'b0;
            page_size_reg <= '0;
            cache_reg     <= icfe_pkg::EXT_ADDR_RESET;
        end
        else
        begin
            if (cfg.valid && (cfg.index == icfe_pkg::REG_EXT_MODE))
            begin
                ext_mode_reg <= cfg.data[0];
            end
            if (cfg.valid && (cfg.index == icfe_pkg::REG_PAGE_SIZE))
            begin
                page_size_reg <= cfg.data[icfe_pkg::PAGE_W-1:0];
            end
            if (accept)
            begin
                cache_reg <= cache_next;
            end
        end
    end

endmodule

### src/icfe_queue.sv
// ----------------------------------------------------------------------------
// icfe_queue
// Short frame queue between the request decode and the byte sequencer.
// ----------------------------------------------------------------------------
module icfe_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  icfe_pkg::frame_t        push_frame,
    input  logic                    pop,
    output icfe_pkg::frame_t        head,
    output icfe_pkg::queue_status_t status
);

    localparam int PTR_W = $clog2(icfe_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(icfe_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(icfe_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(icfe_pkg::QUEUE_DEPTH);

    icfe_pkg::frame_t   entry_reg [icfe_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Frame storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

### src/icfe_back.sv
// ----------------------------------------------------------------------------
// icfe_back
// Sends the head frame out one byte beat per cycle while tx is ready, through an output register.
// ----------------------------------------------------------------------------
module icfe_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  icfe_pkg::frame_t        head,
    input  icfe_pkg::queue_status_t q_status,
    output logic                    pop,
    icfe_byte_if.source             tx
);

    logic [icfe_pkg::FRAME_IDX_W-1:0] idx_reg;
    logic [icfe_pkg::FRAME_IDX_W-1:0] idx_next;
    logic                             valid_reg;
    logic [icfe_pkg::BYTE_W-1:0]      byte_reg;
    logic                             last_reg;
    logic                             cap_reg;
    logic                             load;
    logic                             last_byte;

    localparam logic [icfe_pkg::FRAME_IDX_W-1:0] LAST_IDX =
        icfe_pkg::FRAME_IDX_W'(icfe_pkg::FRAME_LEN - 1);

    // Load a new beat when the queue holds a frame and the output register is free or being drained.
    assign last_byte = (idx_reg == LAST_IDX);
    assign load      = !q_status.empty && (!valid_reg || tx.ready);
    assign pop       = load && last_byte;
    assign idx_next  = load ? idx_reg + 1'b1 : idx_reg;

    assign tx.valid         = valid_reg;
    assign tx.tx_byte       = byte_reg;
    assign tx.last_of_frame = last_reg;
    assign tx.capture_reply = cap_reg;

    // Byte counter and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (tx.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head.bytes[idx_reg];
            last_reg <= last_byte;
            cap_reg  <= head.cap_en && (head.cap_idx == idx_reg);
        end
    end

endmodule

### src/isp_command_frame_encoder_top.sv
// ----------------------------------------------------------------------------
// isp_command_frame_encoder_top
// Serial programming instruction frame encoder: requests in, frame bytes out.
//
//   Channel  Dir  Beat contents
//   req      in   action, target_address, write_data, extended_address
//   tx       out  tx_byte, last_of_frame, capture_reply
//   cfg      in   index (0 extended_mode, 1 page_size), data
//
// A request is decoded in the cycle it is accepted and its frame is written to
// the queue at the accepting edge; its first byte beat is then loaded from the
// queue entry into the output register once that register is free or drained.
// A frame goes out on tx one byte beat per cycle while tx is ready, set by the
// byte sequencer; requests with no frame write nothing to the queue.
// Up to two decoded frames wait in the queue, so req keeps flowing while tx
// is stalled. Reset clears the queue, the output valid and the configuration,
// and sets the extended address cache to 0xFF.
// ----------------------------------------------------------------------------
module isp_command_frame_encoder_top (
    input  logic        clk,
    input  logic        rst_n,
    icfe_req_if.sink    req,
    icfe_byte_if.source tx,
    icfe_cfg_if.sink    cfg
);

    icfe_pkg::frame_t        push_frame;
    icfe_pkg::frame_t        head;
    icfe_pkg::queue_status_t q_status;
    logic                    push;
    logic                    pop;

    // Request decode.
    icfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg      (cfg),
        .q_status (q_status),
        .push     (push),
        .frame    (push_frame)
    );

    // Frame queue.
    icfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // Byte sequencer.
    icfe_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .tx       (tx)
    );

    // The queue is never reported full and empty at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("frame queue reports full and empty");

    // A frame is never pushed into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("frame pushed into a full queue");

    // Nothing is popped from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("frame popped from an empty queue");

    // The only captured byte before the last one is the program enable echo.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && tx.capture_reply && !tx.last_of_frame) |-> (tx.tx_byte == 8'h00))
        else $error("unexpected capture on a middle byte");

endmodule
